@@ design/rctb_pkg.sv @@
package rctb_pkg;

	// Field widths of the time display and the counters.
	localparam int unsigned FULL_W  = 6;
	localparam int unsigned HOLD_W  = 12;
	localparam int unsigned MIN_W   = 7;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MSEC_W  = 10;
	localparam int unsigned CFG_D_W = 12;

	// Reset values of the configuration registers.
	localparam logic [FULL_W-1:0] FULL_MINUTES_RST = FULL_W'(5);
	localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST   = HOLD_W'(800);

	// Mixed-radix limits: ms within a second, seconds within a minute.
	localparam logic [MSEC_W-1:0] MSEC_MAX = MSEC_W'(999);
	localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);
	// Counting up stops at 99:59.999.
	localparam logic [MIN_W-1:0]  UP_MIN_MAX = MIN_W'(99);
	localparam logic [HOLD_W-1:0] HOLD_MAX   = HOLD_W'(4095);

	typedef enum logic [0:0] {
		CFG_FULL_MINUTES = 1'b0,
		CFG_HOLD_LIMIT   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		cfg_idx_t             index;
		logic [CFG_D_W-1:0]   value;
	} cfg_t;

	typedef struct packed {
		logic button_pressed;
	} tick_t;

	typedef struct packed {
		logic              running;
		logic              counting_up;
		logic [MIN_W-1:0]  minutes;
		logic [SEC_W-1:0]  seconds;
		logic              short_press;
		logic              long_press;
	} result_t;

	// Button events of one tick.
	typedef struct packed {
		logic short_press;
		logic long_press;
	} btn_ev_t;

	// Race time as sign and magnitude: up = 1 when at or past zero.
	typedef struct packed {
		logic              up;
		logic [MIN_W-1:0]  minutes;
		logic [SEC_W-1:0]  seconds;
		logic [MSEC_W-1:0] msec;
	} race_time_t;

endpackage

@@ design/rctb_if.sv @@
interface rctb_tick_if;
	import rctb_pkg::*;
	logic  valid;
	logic  ready;
	tick_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rctb_result_if;
	import rctb_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rctb_cfg_if;
	import rctb_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/rctb_button.sv @@
module rctb_button
	import rctb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              button_pressed,
	input  logic [HOLD_W-1:0] hold_limit,
	output btn_ev_t           ev
);

	logic              prev_q;
	logic [HOLD_W-1:0] hold_q;
	logic              fired_q;

	logic [HOLD_W-1:0] hold_n;
	logic              fired_n;
	logic              fired_next;

	// Clear the hold on the press edge, else count pressed ticks up to saturation.
	always_comb begin
		hold_n  = hold_q;
		fired_n = fired_q;
		if (button_pressed && !prev_q) begin
			hold_n  = '0;
			fired_n = 1'b0;
		end else if (button_pressed && hold_q != HOLD_MAX) begin
			hold_n = hold_q + HOLD_W'(1);
		end
		ev.long_press  = button_pressed && !fired_n && (hold_n >= hold_limit);
		ev.short_press = !button_pressed && prev_q && !fired_q;
		fired_next     = fired_n | ev.long_press;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			hold_q  <= '0;
			fired_q <= 1'b0;
		end else if (advance) begin
			prev_q  <= button_pressed;
			hold_q  <= hold_n;
			fired_q <= fired_next;
		end
	end

endmodule

@@ design/rctb_timer.sv @@
module rctb_timer
	import rctb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  btn_ev_t           ev,
	input  logic [FULL_W-1:0] full_minutes,
	output result_t           res
);

	logic       running_q;
	race_time_t time_q;

	race_time_t dec_t;
	race_time_t next_t;
	race_time_t full_t;
	logic       running_n;

	// Full countdown value; a zero duration lands directly on zero.
	always_comb begin
		full_t.up      = (full_minutes == '0);
		full_t.minutes = {{(MIN_W-FULL_W){1'b0}}, full_minutes};
		full_t.seconds = '0;
		full_t.msec    = '0;
	end

	// Let one millisecond pass: shrink the magnitude before zero, grow it after.
	always_comb begin
		dec_t = time_q;
		if (running_q) begin
			if (!time_q.up) begin
				if (time_q.minutes == '0 && time_q.seconds == '0 &&
				    time_q.msec == MSEC_W'(1)) begin
					dec_t.up = 1'b1;
				end
				if (time_q.msec != '0) begin
					dec_t.msec = time_q.msec - MSEC_W'(1);
				end else begin
					dec_t.msec = MSEC_MAX;
					if (time_q.seconds != '0) begin
						dec_t.seconds = time_q.seconds - SEC_W'(1);
					end else begin
						dec_t.seconds = SEC_MAX;
						dec_t.minutes = time_q.minutes - MIN_W'(1);
					end
				end
			end else if (!(time_q.minutes == UP_MIN_MAX && time_q.seconds == SEC_MAX &&
			              time_q.msec == MSEC_MAX)) begin
				if (time_q.msec != MSEC_MAX) begin
					dec_t.msec = time_q.msec + MSEC_W'(1);
				end else begin
					dec_t.msec = '0;
					if (time_q.seconds != SEC_MAX) begin
						dec_t.seconds = time_q.seconds + SEC_W'(1);
					end else begin
						dec_t.seconds = '0;
						dec_t.minutes = time_q.minutes + MIN_W'(1);
					end
				end
			end
		end
	end

	// Apply button events: long press drops to idle, short press works the timer.
	always_comb begin
		next_t    = dec_t;
		running_n = running_q;
		if (ev.long_press) begin
			running_n = 1'b0;
		end else if (ev.short_press) begin
			running_n = 1'b1;
			if (running_q && !dec_t.up) begin
				next_t.seconds = '0;
				next_t.msec    = '0;
				if (dec_t.minutes == '0) begin
					next_t.up = 1'b1;
				end
			end else begin
				next_t = full_t;
			end
		end
	end

	// Display: idle shows the full duration; round up to seconds before zero, down after.
	always_comb begin
		res.running     = running_n;
		res.counting_up = 1'b0;
		res.minutes     = next_t.minutes;
		res.seconds     = next_t.seconds;
		res.short_press = ev.short_press;
		res.long_press  = ev.long_press;
		if (!running_n) begin
			res.minutes = {{(MIN_W-FULL_W){1'b0}}, full_minutes};
			res.seconds = '0;
		end else if (next_t.up) begin
			res.counting_up = 1'b1;
		end else if (next_t.msec != '0) begin
			if (next_t.seconds == SEC_MAX) begin
				res.seconds = '0;
				res.minutes = next_t.minutes + MIN_W'(1);
			end else begin
				res.seconds = next_t.seconds + SEC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			time_q    <= '{up: 1'b1, minutes: '0, seconds: '0, msec: '0};
		end else if (advance) begin
			running_q <= running_n;
			time_q    <= next_t;
		end
	end

endmodule

@@ design/race_countdown_timer_button_unit.sv @@
// Race countdown timer worked by one select button, one tick transaction per millisecond.
// An accepted tick passes the tick stage register and then the result register.
// Throughput: one tick per cycle while results are taken; the tick stage register and the
// result register let a new tick enter while a finished result still waits to be taken.
// Reset (arst_n low, asynchronous): timer idle, button released, hold count clear,
// full_minutes = 5, long-press hold limit = 800, no transaction in flight.
module race_countdown_timer_button_unit
	import rctb_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	rctb_tick_if.sink      tick,
	rctb_result_if.source  result,
	rctb_cfg_if.sink       cfg
);

	// Configuration registers
	logic [FULL_W-1:0] full_minutes_q;
	logic [HOLD_W-1:0] hold_limit_q;

	// Tick stage
	logic    s1_valid_q;
	tick_t   tick_s1;

	// Result register
	logic    res_valid_q;
	result_t res_q;

	logic    res_free;
	logic    advance;
	btn_ev_t ev;
	result_t res_n;

	// The result register frees up when empty or when its transaction is taken.
	assign res_free     = !res_valid_q || result.ready;
	// Hand the staged tick to the state and the result register.
	assign advance      = s1_valid_q && res_free;
	// Take a new tick whenever the stage is empty or moves on this cycle.
	assign tick.ready   = !s1_valid_q || res_free;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;
	// The user must write the configuration only while idle; the block does not enforce this and always takes writes.
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_minutes_q <= FULL_MINUTES_RST;
			hold_limit_q   <= HOLD_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_FULL_MINUTES: full_minutes_q <= cfg.data.value[FULL_W-1:0];
				CFG_HOLD_LIMIT:   hold_limit_q   <= cfg.data.value[HOLD_W-1:0];
			endcase
		end
	end

	// Stage the incoming tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tick.ready) begin
			s1_valid_q <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.data;
		end
	end

	// Press and release edges, hold timing and long-press detection.
	rctb_button u_button (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.button_pressed (tick_s1.button_pressed),
		.hold_limit     (hold_limit_q),
		.ev             (ev)
	);

	// Race time: advance one ms, apply the button events, build the display.
	rctb_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.ev           (ev),
		.full_minutes (full_minutes_q),
		.res          (res_n)
	);

	// Hold the result until taken; load a fresh one as the tick moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	// A staged tick that cannot move on must stay staged.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !res_free) |=> s1_valid_q)
		else $error("staged tick lost while the result register was full");

	// Idle results show the full duration with zero seconds, never counting up.
	a_idle_display: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.running) |-> (!res_q.counting_up && res_q.seconds == '0))
		else $error("idle result shows running time");

	// A tick is either a release or a hold, never both kinds of press.
	a_press_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.short_press && res_q.long_press))
		else $error("short and long press on the same tick");

	// Seconds stay below one minute.
	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.seconds <= SEC_MAX))
		else $error("seconds out of range");

endmodule
